// ----- sv/tbl_pkg.sv -----
package tbl_pkg;

   localparam int unsigned MaxEntries = 16;
   localparam int unsigned TpsWidth   = 21;
   localparam int unsigned TokWidth   = 37;
   localparam logic [TpsWidth-1:0] TpsReset = 21'd1000;

   typedef enum logic [2:0] {
      ST_ALLOW        = 3'd0,
      ST_REJECT_QUEUE = 3'd1,
      ST_REJECT_RATE  = 3'd2,
      ST_CONFIGURED   = 3'd3,
      ST_NO_SLOT      = 3'd4
   } status_type;

   // per-entry bucket record held in memory
   typedef struct packed {
      logic [15:0]         rate;
      logic [15:0]         qlimit;
      logic [TokWidth-1:0] tokens;
      logic [31:0]         last_time;
   } bucket_type;

endpackage

// ----- sv/per_vm_token_bucket_limiter.sv -----
// channel | ports                                              | direction
// req     | req_valid/req_ready, action, vm_id, now_ticks, ... | in
// rsp     | rsp_valid/rsp_ready, rsp_status                    | out
// csr     | csr_wr_en, csr_wr_data (ticks per second)          | in
//
// a beat runs in order: id match against the vm id flops on the accept
// cycle, bucket ram read from the latched index, refill/consume/writeback, then
// the status beat; one beat in flight at a time
// the refill products are 21x16: elapsed*rate and tps*rate
// reset clears valid bits and loads the tps register with 1000; the bucket ram needs no clearing
// a finished status waits in RESP for as long as rsp_ready stays low;
// a new beat is taken only once the old status beat left
module per_vm_token_bucket_limiter #(
   parameter int unsigned MAX_ENTRIES = tbl_pkg::MaxEntries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_vm_id,
   input  logic [31:0] req_now_ticks,
   input  logic [15:0] req_queue_depth,
   input  logic [15:0] req_rate,
   input  logic [15:0] req_queue_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [tbl_pkg::TpsWidth-1:0] csr_wr_data
);

   localparam int unsigned IdxW = $clog2(MAX_ENTRIES > 1 ? MAX_ENTRIES : 2);
   localparam int unsigned TokW = tbl_pkg::TokWidth;
   localparam int unsigned TpsW = tbl_pkg::TpsWidth;
   localparam int unsigned BktW = $bits(tbl_pkg::bucket_type);

   typedef enum logic [1:0] {IDLE, READ, CALC, RESP} state_type;

   state_type state_ff;
   logic [TpsW-1:0] tps_ff;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0] vm_ff [MAX_ENTRIES];

   // latched beat
   logic        act_ff;
   logic [31:0] id_ff, now_ff;
   logic [15:0] depth_ff, rate_ff, qlim_ff;
   logic        hit_ff, free_ok_ff;
   logic [IdxW-1:0] idx_ff;
   logic [2:0]  status_ff;
   logic [2:0]  status_in;

   // tps of zero counts as one
   logic [TpsW-1:0] tps_eff;
   assign tps_eff = (tps_ff == '0) ? TpsW'(1) : tps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= tbl_pkg::TpsReset;
      end else if (csr_wr_en) begin
         tps_ff <= csr_wr_data;
      end
   end

   // parallel id match and lowest free slot search over the flop array
   logic            hit_c, free_c;
   logic [IdxW-1:0] hit_idx_c, free_idx_c;
   always_comb begin
      hit_c = 1'b0;
      free_c = 1'b0;
      hit_idx_c = '0;
      free_idx_c = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && vm_ff[i] == req_vm_id) begin
            hit_c = 1'b1;
            hit_idx_c = IdxW'(i);
         end
         if (!valid_ff[i]) begin
            free_c = 1'b1;
            free_idx_c = IdxW'(i);
         end
      end
   end

   logic accept;
   assign req_ready = (state_ff == IDLE);
   assign accept = req_valid && req_ready;

   // bucket ram, read in READ from the latched index
   tbl_pkg::bucket_type rd_bkt, wr_bkt;
   logic ram_we;
   logic [BktW-1:0] rd_raw;
   tbl_ram #(.WIDTH(BktW), .DEPTH(MAX_ENTRIES)) u_bkt (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(idx_ff),
      .wr_data(wr_bkt),
      .rd_addr(idx_ff),
      .rd_data(rd_raw)
   );
   assign rd_bkt = tbl_pkg::bucket_type'(rd_raw);

   // refill math on the read bucket
   logic [31:0] elapsed;
   logic [TpsW-1:0] el_clamp;
   logic [TokW-1:0] gain, cap, sum, refilled, tok_new;
   logic [TokW:0] sum_w;
   logic enough;
   always_comb begin
      elapsed  = now_ff - rd_bkt.last_time;
      el_clamp = (elapsed > 32'(tps_eff)) ? tps_eff : elapsed[TpsW-1:0];
      gain     = TokW'(el_clamp * rd_bkt.rate);
      cap      = TokW'(tps_eff * rd_bkt.rate);
      sum_w    = {1'b0, rd_bkt.tokens} + {1'b0, gain};
      sum      = (sum_w > {1'b0, cap}) ? cap : sum_w[TokW-1:0];
      refilled = (elapsed == '0) ? rd_bkt.tokens : sum;
      enough   = refilled >= TokW'(tps_eff);
      tok_new  = enough ? refilled - TokW'(tps_eff) : refilled;
   end

   logic [TokW-1:0] cfg_tok;
   assign cfg_tok = TokW'(rate_ff * tps_eff);

   always_comb begin
      ram_we   = 1'b0;
      wr_bkt   = rd_bkt;
      valid_in = valid_ff;
      status_in = tbl_pkg::ST_ALLOW;
      if (act_ff) begin
         if (hit_ff || free_ok_ff) begin
            ram_we = (state_ff == CALC);
            wr_bkt.rate = rate_ff;
            wr_bkt.qlimit = qlim_ff;
            wr_bkt.tokens = cfg_tok;
            wr_bkt.last_time = now_ff;
            valid_in[idx_ff] = 1'b1;
            status_in = tbl_pkg::ST_CONFIGURED;
         end else begin
            status_in = tbl_pkg::ST_NO_SLOT;
         end
      end else if (!hit_ff) begin
         status_in = tbl_pkg::ST_ALLOW;
      end else if (rd_bkt.qlimit != '0 && depth_ff >= rd_bkt.qlimit) begin
         status_in = tbl_pkg::ST_REJECT_QUEUE;
      end else if (rd_bkt.rate == '0) begin
         status_in = tbl_pkg::ST_ALLOW;
      end else begin
         ram_we = (state_ff == CALC);
         wr_bkt.tokens = tok_new;
         if (elapsed != '0) begin
            wr_bkt.last_time = now_ff;
         end
         status_in = enough ? tbl_pkg::ST_ALLOW : tbl_pkg::ST_REJECT_RATE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= '0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= READ;
               end
            end
            READ: state_ff <= CALC;
            CALC: begin
               state_ff <= RESP;
               valid_ff <= valid_in;
            end
            RESP: begin
               if (rsp_ready) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         id_ff <= req_vm_id;
         now_ff <= req_now_ticks;
         depth_ff <= req_queue_depth;
         rate_ff <= req_rate;
         qlim_ff <= req_queue_limit;
         hit_ff <= hit_c;
         free_ok_ff <= free_c;
         idx_ff <= hit_c ? hit_idx_c : free_idx_c;
      end
      if (state_ff == CALC) begin
         status_ff <= status_in;
         if (act_ff && (hit_ff || free_ok_ff)) begin
            vm_ff[idx_ff] <= id_ff;
         end
      end
   end

   assign rsp_valid  = (state_ff == RESP);
   assign rsp_status = status_ff;

`ifndef SYNTHESIS
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("beat accepted while busy");
   a_rsp_after_calc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == CALC)
      else $error("response without calc");
   a_no_ram_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == CALC)
      else $error("ram write outside calc");
`endif

endmodule

// ----- sv/tbl_ram.sv -----
module tbl_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
